[hw/rtl/fwur_pkg.sv]
// ----------------------------------------------------------------------------
// fwur_pkg
// Shared types and constants of the firmware update receiver.
// ----------------------------------------------------------------------------
package fwur_pkg;

  localparam int WORD_W  = 32;
  localparam int INDEX_W = 16;
  localparam int LEN_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int PSUM_W  = 20;

  localparam int DEFAULT_MAX_FRAME_BYTES = 1024;

  localparam logic [WORD_W-1:0] HDR_MASK  = 32'h2FFE_0000;
  localparam logic [WORD_W-1:0] HDR_VALUE = 32'h2002_0000;

  localparam logic [LEN_W-1:0] VERIFY_LEN = 11'd4;

  typedef enum logic [2:0] {
    OP_VERSION = 3'd0,
    OP_BEGIN   = 3'd1,
    OP_DATA    = 3'd2,
    OP_VERIFY  = 3'd3,
    OP_REBOOT  = 3'd4,
    OP_READY   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OTHER      = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_FLASH_FAIL = 3'd4,
    ST_BAD_VERIFY = 3'd5
  } status_t;

endpackage

[hw/rtl/firmware_update_receiver.sv]
// ----------------------------------------------------------------------------
// firmware_update_receiver
// Collects the payload bytes of update frames and answers each frame on its
// final byte with one acknowledge carrying a status code and progress.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    op, frame index, length, byte
//   out_     output     out_valid / out_ready  status, kind, flags, progress
//
// One request is taken every cycle while in_ready is high; each is folded into the frame and
// progress registers in the cycle it is accepted.
// A final byte loads the acknowledge register, which holds until taken.
// in_ready drops only while an acknowledge waits and out_ready is low.
// Reset clears all progress, checksum and frame state.
// ----------------------------------------------------------------------------
module firmware_update_receiver
  import fwur_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [INDEX_W-1:0] in_frame_number,
  input  logic [LEN_W-1:0]   in_frame_length,
  input  logic [BYTE_W-1:0]  in_payload_byte,
  input  logic               in_first_byte,
  input  logic               in_last_byte,
  input  logic               in_flash_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [2:0]         out_echo_kind,
  output logic               out_reboot_request,
  output logic               out_upgrade_ready,
  output logic [WORD_W-1:0]  out_write_offset,
  output logic [WORD_W-1:0]  out_running_sum
);

  localparam logic [WORD_W-1:0] MaxLen = WORD_W'(MAX_FRAME_BYTES);

  logic [WORD_W-1:0]  image_size_r, image_size_nxt;
  logic [INDEX_W-1:0] next_index_r, next_index_nxt;
  logic [WORD_W-1:0]  flash_offset_r, flash_offset_nxt;
  logic               header_ok_r, header_ok_nxt;
  logic [WORD_W-1:0]  sum_r, sum_nxt;
  logic [PSUM_W-1:0]  pending_sum_r, pending_sum_nxt;
  logic [WORD_W-1:0]  first_word_r, first_word_nxt;
  logic [LEN_W-1:0]   byte_count_r, byte_count_nxt;
  logic               ready_flag_r, ready_flag_nxt;

  logic               out_valid_r;
  status_t            out_status_r, status_nxt;
  logic [2:0]         out_echo_kind_r;
  logic               out_reboot_r, reboot_nxt;
  logic               out_ready_flag_r;
  logic [WORD_W-1:0]  out_offset_r;
  logic [WORD_W-1:0]  out_sum_r;

  logic               in_accept;
  logic [LEN_W-1:0]   eff_len;
  logic [WORD_W-1:0]  fw0, fw1;
  logic [PSUM_W-1:0]  ps0, ps1;
  logic [LEN_W-1:0]   bc0, bc1;
  logic               absorb;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  assign eff_len = ({{(WORD_W-LEN_W){1'b0}}, in_frame_length} < MaxLen) ?
                   in_frame_length : MaxLen[LEN_W-1:0];

  always_comb begin
    fw0    = in_first_byte ? '0 : first_word_r;
    ps0    = in_first_byte ? '0 : pending_sum_r;
    bc0    = in_first_byte ? '0 : byte_count_r;
    absorb = bc0 < eff_len;
    fw1    = fw0;
    ps1    = ps0;
    bc1    = bc0;
    if (absorb) begin
      if (bc0 < LEN_W'(4)) begin
        fw1 = fw0 | (WORD_W'(in_payload_byte) << {bc0[1:0], 3'b000});
      end
      ps1 = ps0 + PSUM_W'(in_payload_byte);
      bc1 = bc0 + LEN_W'(1);
    end
  end

  always_comb begin
    image_size_nxt   = image_size_r;
    next_index_nxt   = next_index_r;
    flash_offset_nxt = flash_offset_r;
    header_ok_nxt    = header_ok_r;
    sum_nxt          = sum_r;
    ready_flag_nxt   = ready_flag_r;
    first_word_nxt   = fw1;
    pending_sum_nxt  = ps1;
    byte_count_nxt   = bc1;
    status_nxt       = ST_OTHER;
    reboot_nxt       = 1'b0;
    if (in_last_byte) begin
      first_word_nxt  = '0;
      pending_sum_nxt = '0;
      byte_count_nxt  = '0;
      case (in_op)
        OP_VERSION: begin
          status_nxt = ST_OK;
        end
        OP_BEGIN: begin
          next_index_nxt   = '0;
          flash_offset_nxt = '0;
          header_ok_nxt    = 1'b0;
          sum_nxt          = '0;
          image_size_nxt   = fw1;
          status_nxt       = in_flash_ok ? ST_OK : ST_OTHER;
        end
        OP_DATA: begin
          if (next_index_r != in_frame_number) begin
            status_nxt = ST_BAD_INDEX;
          end else if (in_frame_number == '0 && flash_offset_r == '0 &&
                       (fw1 & HDR_MASK) != HDR_VALUE) begin
            status_nxt = ST_BAD_HEADER;
          end else begin
            if (in_frame_number == '0 && flash_offset_r == '0) begin
              header_ok_nxt = 1'b1;
            end
            if (!in_flash_ok) begin
              status_nxt = ST_FLASH_FAIL;
            end else begin
              next_index_nxt   = next_index_r + INDEX_W'(1);
              flash_offset_nxt = flash_offset_r + WORD_W'(eff_len);
              sum_nxt          = ~(sum_r + WORD_W'(ps1));
              status_nxt       = ST_OK;
            end
          end
        end
        OP_VERIFY: begin
          if (in_frame_length == VERIFY_LEN) begin
            status_nxt = (sum_r == fw1) ? ST_OK : ST_OTHER;
          end else begin
            status_nxt = ST_BAD_VERIFY;
          end
        end
        OP_REBOOT: begin
          reboot_nxt = 1'b1;
          status_nxt = ST_OTHER;
        end
        OP_READY: begin
          ready_flag_nxt = 1'b1;
          status_nxt     = ST_OK;
        end
        default: begin
          status_nxt = ST_OTHER;
        end
      endcase
      if (status_nxt != ST_OK) begin
        image_size_nxt   = '0;
        next_index_nxt   = '0;
        flash_offset_nxt = '0;
        header_ok_nxt    = 1'b0;
      end
      if (reboot_nxt) begin
        sum_nxt        = '0;
        ready_flag_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r   <= '0;
      next_index_r   <= '0;
      flash_offset_r <= '0;
      header_ok_r    <= 1'b0;
      sum_r          <= '0;
      pending_sum_r  <= '0;
      first_word_r   <= '0;
      byte_count_r   <= '0;
      ready_flag_r   <= 1'b0;
    end else if (in_accept) begin
      image_size_r   <= image_size_nxt;
      next_index_r   <= next_index_nxt;
      flash_offset_r <= flash_offset_nxt;
      header_ok_r    <= header_ok_nxt;
      sum_r          <= sum_nxt;
      pending_sum_r  <= pending_sum_nxt;
      first_word_r   <= first_word_nxt;
      byte_count_r   <= byte_count_nxt;
      ready_flag_r   <= ready_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_last_byte) begin
      out_status_r     <= status_nxt;
      out_echo_kind_r  <= in_op;
      out_reboot_r     <= reboot_nxt;
      out_ready_flag_r <= ready_flag_nxt;
      out_offset_r     <= flash_offset_nxt;
      out_sum_r        <= sum_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_echo_kind      = out_echo_kind_r;
  assign out_reboot_request = out_reboot_r;
  assign out_upgrade_ready  = out_ready_flag_r;
  assign out_write_offset   = out_offset_r;
  assign out_running_sum    = out_sum_r;

`ifndef SYNTHESIS
  a_no_ack_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_last_byte && out_ready) |=> !out_valid)
    else $error("acknowledge produced for a non-final byte");

  a_reboot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reboot_request) |->
      (out_write_offset == '0 && out_running_sum == '0 && !out_upgrade_ready &&
       out_status == ST_OTHER))
    else $error("reboot acknowledge does not report cleared state");

  a_fail_clears_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_write_offset == '0))
    else $error("failed request kept a nonzero flash offset");
`endif

endmodule
